// ===== hw/rtl/bfa_pkg.sv =====
// Shared constants and types of the bitmap frame allocator.
// Used by bitmap_frame_allocator; depends on nothing else.
package bfa_pkg;

  localparam int MAX_FRAMES    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_DEPTH     = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int ADDR_W = $clog2(MAP_DEPTH);
  localparam int BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int IDX_W  = ADDR_W + BIT_W;
  localparam int SIZE_W = IDX_W + 1;

  localparam int FRAME_W = 20;
  localparam int COUNT_W = 13;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 1;

  // Each memory word holds the allocated bits low and the inaccessible bits high.
  localparam int RAM_W = 2 * MAP_WORD_BITS;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_MARK    = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NONE_FREE    = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_INACCESSIBLE = 3'd3,
    ST_RANGE        = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE   = 1'b0,
    REG_POOL_FRAMES = 1'b1
  } cfg_reg_e;

endpackage

// ===== hw/rtl/bfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Bitmap frame allocator: top level. Holds both bitmaps in one bfa_ram and
// runs allocate, release and mark as word-wise read-modify-write sequences.
// Depends on bfa_pkg and bfa_ram.
//
// One beat on the input stream yields exactly one result beat. An item is taken
// only while the block is idle; it passes through range checking and then
// walks the bitmap memory one word per cycle, with reads pipelined one ahead of
// the write-back. Allocate visits words from the bottom until it finds a free
// frame or reaches the last word of the pool. Release touches one word. Mark
// touches every word that its range covers. The maps are empty after reset
// without any clearing pass: a valid flag per word makes an unwritten word read
// as zero. A finished result waits in the output register, and the next item is
// taken while it waits.
module bitmap_frame_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bfa_pkg::CFG_W-1:0]         cfg_data_i,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: frame_no[19:0], count[32:20], zero fill.
  input  logic [bfa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0 up: func[1:0].
  input  logic [bfa_pkg::FUNC_W-1:0]        s_axis_tuser,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: frame_out[19:0], zero fill.
  output logic [bfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0 up: status[2:0].
  output logic [bfa_pkg::STAT_W-1:0]        m_axis_tuser
);

  localparam int WB = bfa_pkg::MAP_WORD_BITS;
  localparam int AW = bfa_pkg::ADDR_W;
  localparam int BW = bfa_pkg::BIT_W;
  localparam int IW = bfa_pkg::IDX_W;
  localparam int SW = bfa_pkg::SIZE_W;
  localparam int FW = bfa_pkg::FRAME_W;
  localparam int CW = bfa_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [FW-1:0] base_q;
  logic [CW-1:0] frames_q;

  // Latched item.
  bfa_pkg::func_e func_q;
  logic [FW-1:0]  fno_q;
  logic [CW-1:0]  cnt_q;
  logic [SW-1:0]  size_q;

  // Walk bounds: first and last frame index touched.
  logic [IW-1:0] off_q;
  logic [IW-1:0] end_q;

  // Read pipeline.
  logic [AW-1:0] issue_q;
  logic          issue_done_q;
  logic          pend_q;
  logic [AW-1:0] pend_addr_q;
  logic          pend_vld_q;
  logic [bfa_pkg::MAP_DEPTH-1:0] map_vld_q;

  // Result staging and output register.
  logic [FW-1:0]            res_frame_q, res_frame_d;
  bfa_pkg::status_e         res_status_q, res_status_d;
  logic                     out_valid_q;
  logic [FW-1:0]            out_frame_q;
  logic [bfa_pkg::STAT_W-1:0] out_status_q;

  logic [SW-1:0] size_w;
  logic          rd_en;
  logic [bfa_pkg::RAM_W-1:0] rdata;
  logic          wr_en;
  logic [WB-1:0] alloc_new, bad_new;
  logic          set_walk;
  logic [IW-1:0] off_d, end_d;

  assign s_axis_tready = (state_q == S_IDLE);

  // Pool size, clamped to the capacity of the maps.
  assign size_w = ({19'd0, frames_q} > 32'(bfa_pkg::MAX_FRAMES)) ?
                  SW'(bfa_pkg::MAX_FRAMES) : SW'(frames_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      frames_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bfa_pkg::cfg_reg_e'(cfg_idx_i))
        bfa_pkg::REG_POOL_BASE:   base_q   <= cfg_data_i[FW-1:0];
        bfa_pkg::REG_POOL_FRAMES: frames_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Range checks on the latched item.
  logic [FW:0]   diff_w;
  logic [FW:0]   span_w;
  logic          below_w;

  assign diff_w  = {1'b0, fno_q} - {1'b0, base_q};
  assign below_w = diff_w[FW];
  assign span_w  = {1'b0, diff_w[FW-1:0]} + (FW+1)'(cnt_q);

  // Word-level processing of the read data.
  logic [WB-1:0] alloc_w, bad_w, busy_w, limit_w, mark_w, bit_w;
  logic [BW-1:0] zero_idx, lo_w, hi_w, rel_bit;
  logic          last_word;

  assign alloc_w   = pend_vld_q ? rdata[WB-1:0] : '0;
  assign bad_w     = pend_vld_q ? rdata[2*WB-1:WB] : '0;
  assign last_word = (pend_addr_q == end_q[IW-1:BW]);
  assign rel_bit   = off_q[BW-1:0];
  assign lo_w      = (pend_addr_q == off_q[IW-1:BW]) ? off_q[BW-1:0] : '0;
  assign hi_w      = last_word ? end_q[BW-1:0] : BW'(WB - 1);

  always_comb begin
    for (int i = 0; i < WB; i++) begin
      limit_w[i] = ({1'b0, pend_addr_q, BW'(i)} >= size_q);
      mark_w[i]  = (BW'(i) >= lo_w) && (BW'(i) <= hi_w);
    end
  end

  assign busy_w = alloc_w | bad_w | limit_w;

  always_comb begin
    zero_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!busy_w[i]) begin
        zero_idx = BW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    set_walk     = 1'b0;
    off_d        = off_q;
    end_d        = end_q;
    wr_en        = 1'b0;
    alloc_new    = alloc_w;
    bad_new      = bad_w;
    bit_w        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_frame_d  = '0;
        res_status_d = bfa_pkg::ST_OK;
        state_d      = S_RESP;
        case (func_q)
          bfa_pkg::FUNC_ALLOC: begin
            if (size_q == '0) begin
              res_status_d = bfa_pkg::ST_NONE_FREE;
            end else begin
              off_d    = '0;
              end_d    = IW'(size_q - SW'(1));
              set_walk = 1'b1;
              state_d  = S_SCAN;
            end
          end
          bfa_pkg::FUNC_RELEASE: begin
            if (below_w || (diff_w[FW-1:0] >= FW'(size_q))) begin
              res_status_d = bfa_pkg::ST_RANGE;
            end else begin
              off_d    = diff_w[IW-1:0];
              end_d    = diff_w[IW-1:0];
              set_walk = 1'b1;
              state_d  = S_SCAN;
            end
          end
          bfa_pkg::FUNC_MARK: begin
            if (below_w || (span_w > (FW+1)'(size_q))) begin
              res_status_d = bfa_pkg::ST_RANGE;
            end else if (cnt_q != '0) begin
              off_d    = diff_w[IW-1:0];
              end_d    = IW'(span_w - (FW+1)'(1));
              set_walk = 1'b1;
              state_d  = S_SCAN;
            end
          end
          default: res_status_d = bfa_pkg::ST_RANGE;
        endcase
      end
      S_SCAN: begin
        if (pend_q) begin
          case (func_q)
            bfa_pkg::FUNC_ALLOC: begin
              if (!(&busy_w)) begin
                bit_w        = WB'(1) << zero_idx;
                alloc_new    = alloc_w | bit_w;
                wr_en        = 1'b1;
                res_frame_d  = base_q + FW'({pend_addr_q, zero_idx});
                res_status_d = bfa_pkg::ST_OK;
                state_d      = S_RESP;
              end else if (last_word) begin
                res_status_d = bfa_pkg::ST_NONE_FREE;
                state_d      = S_RESP;
              end
            end
            bfa_pkg::FUNC_RELEASE: begin
              state_d = S_RESP;
              if (!alloc_w[rel_bit]) begin
                res_status_d = bfa_pkg::ST_ALREADY_FREE;
              end else if (bad_w[rel_bit]) begin
                res_status_d = bfa_pkg::ST_INACCESSIBLE;
              end else begin
                bit_w     = WB'(1) << rel_bit;
                alloc_new = alloc_w & ~bit_w;
                wr_en     = 1'b1;
              end
            end
            default: begin
              // Mark: one word of the range per returned read.
              bad_new = bad_w | mark_w;
              wr_en   = 1'b1;
              if (last_word) begin
                state_d = S_RESP;
              end
            end
          endcase
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reads run one word ahead of the write-back, never at the word being written.
  assign rd_en = (state_q == S_SCAN) && !issue_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      map_vld_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (set_walk) begin
        issue_done_q <= 1'b0;
      end else if (rd_en && (issue_q == end_q[IW-1:BW])) begin
        issue_done_q <= 1'b1;
      end
      if (wr_en) begin
        map_vld_q[pend_addr_q] <= 1'b1;
      end
      if ((state_q == S_RESP) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= bfa_pkg::func_e'(s_axis_tuser);
      fno_q  <= s_axis_tdata[FW-1:0];
      cnt_q  <= s_axis_tdata[FW+CW-1:FW];
      size_q <= size_w;
    end
    off_q        <= off_d;
    end_q        <= end_d;
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    if (set_walk) begin
      issue_q <= off_d[IW-1:BW];
    end else if (rd_en) begin
      issue_q <= issue_q + AW'(1);
    end
    pend_addr_q <= issue_q;
    pend_vld_q  <= map_vld_q[issue_q];
    if ((state_q == S_RESP) && (!out_valid_q || m_axis_tready)) begin
      out_frame_q  <= res_frame_q;
      out_status_q <= res_status_q;
    end
  end

  bfa_ram #(
    .WIDTH (bfa_pkg::RAM_W),
    .DEPTH (bfa_pkg::MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pend_addr_q),
    .wdata_i ({bad_new, alloc_new}),
    .re_i    (rd_en),
    .raddr_i (issue_q),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(bfa_pkg::OUT_DATA_W - FW)'(0), out_frame_q};
  assign m_axis_tuser  = out_status_q;

endmodule
